### design/truncated_float32_multiplier_assert.svh
// Assertion macros used by the multiplier's back module (tfm_back).
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef TRUNCATED_FLOAT32_MULTIPLIER_ASSERT_SVH
`define TRUNCATED_FLOAT32_MULTIPLIER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TFM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define TFM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/tfm_pkg.sv
// ----------------------------------------------------------------------------
// tfm_pkg
// Shared types, constants and helpers of the truncated binary32 multiplier.
// ----------------------------------------------------------------------------
package tfm_pkg;

  localparam int TFM_QDEPTH    = 2;
  localparam int TFM_ADDR_W    = 3;
  localparam logic [4:0] TFM_TRUNC_MAX = 5'd22;
  localparam logic [31:0] TFM_QNAN = 32'hFFC0_0000;
  localparam logic [7:0] TFM_EXP_ONES = 8'hFF;

  // register indexes (paddr[2])
  localparam logic REG_TRUNC_BITS = 1'b0;
  localparam logic REG_ROUND_OPS  = 1'b1;

  // classified operand pair handed from front to back
  typedef struct packed {
    logic               special;
    logic [31:0]        spec_val;
    logic               sign;
    logic signed [9:0]  ea;
    logic [23:0]        ma;
    logic signed [9:0]  eb;
    logic [23:0]        mb;
  } tfm_op_t;

  function automatic logic [4:0] eff_trunc(input logic [4:0] t);
    eff_trunc = (t > TFM_TRUNC_MAX) ? TFM_TRUNC_MAX : t;
  endfunction

endpackage

### design/truncated_float32_multiplier.sv
// Path: an accepted item is registered in the front, written to the queue and, when the back
// is free, captured by the back, multiplied, and rounded into the result register.
// The back sequencer holds one item through multiply, round and delivery and takes no new
// one until its result is popped; the front and queue hold up to 3 more.
// Reset (rst_n low, synchronous): both registers read 0, queue and result empty.
// ----------------------------------------------------------------------------
// truncated_float32_multiplier
// Approximate binary32 multiplier with configurable mantissa truncation.
// ----------------------------------------------------------------------------
module truncated_float32_multiplier #(
  parameter int QUEUE_DEPTH = tfm_pkg::TFM_QDEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          push,
  output logic                          full,
  input  logic [31:0]                   in_op_a,
  input  logic [31:0]                   in_op_b,
  // result channel
  output logic                          empty,
  input  logic                          pop,
  output logic [31:0]                   out_product,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tfm_pkg::TFM_ADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import tfm_pkg::*;

  logic [4:0]  trunc_bits_r;
  logic        round_ops_r;
  logic        cfg_wr;
  logic        f_valid, f_take;
  tfm_op_t     f_op, q_data;
  logic        q_full, q_empty, q_pop;

  // Register file: index from paddr[2], always ready.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_ROUND_OPS) ? {31'd0, round_ops_r} : {27'd0, trunc_bits_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trunc_bits_r <= 5'd0;
      round_ops_r  <= 1'b0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_TRUNC_BITS) trunc_bits_r <= pwdata[4:0];
      else round_ops_r <= pwdata[0];
    end
  end

  // Front: advance into the queue whenever it has room.
  assign f_take = f_valid && !q_full;

  tfm_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .trunc_bits     (trunc_bits_r),
    .round_operands (round_ops_r),
    .push           (push),
    .full           (full),
    .in_op_a        (in_op_a),
    .in_op_b        (in_op_b),
    .f_valid        (f_valid),
    .f_take         (f_take),
    .f_op           (f_op)
  );

  // Queue decouples classification from the arithmetic.
  tfm_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (f_take),
    .wr_data (f_op),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .q_empty (q_empty)
  );

  // Back: multiply, round and hold the beat until popped.
  tfm_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .trunc_bits  (trunc_bits_r),
    .q_empty     (q_empty),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .out_product (out_product)
  );

endmodule

### design/tfm_front.sv
// ----------------------------------------------------------------------------
// tfm_front
// Operand narrowing, optional pre-rounding, special-case classification and
// leading-zero normalisation; one register stage.
// ----------------------------------------------------------------------------
module tfm_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [4:0]       trunc_bits,
  input  logic             round_operands,
  input  logic             push,
  output logic             full,
  input  logic [31:0]      in_op_a,
  input  logic [31:0]      in_op_b,
  output logic             f_valid,
  input  logic             f_take,
  output tfm_pkg::tfm_op_t f_op
);
  import tfm_pkg::*;

  logic             valid_r;
  tfm_op_t          op_r;
  tfm_op_t          op_nxt;
  logic [4:0]       t;
  logic [22:0]      lowmask;
  logic [31:0]      wa, wb;
  logic [22:0]      fa, fb;
  logic             nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, zs;
  logic [23:0]      ra, rb;
  logic [4:0]       la, lb;
  logic             load;

  function automatic logic [31:0] pre_round(input logic [31:0] w, input logic [4:0] tt,
                                            input logic en);
    logic [31:0] r;
    r = w;
    if (en && (tt != 5'd0) && w[tt - 5'd1]) r = w + (32'd1 << tt);
    pre_round = r;
  endfunction

  function automatic logic [4:0] lzc24(input logic [23:0] m);
    logic [4:0] n;
    n = 5'd24;
    for (int i = 0; i < 24; i++) begin
      if (m[i]) n = 5'(23 - i);
    end
    lzc24 = n;
  endfunction

  always_comb begin
    t       = eff_trunc(trunc_bits);
    lowmask = (23'd1 << t) - 23'd1;
    wa      = pre_round(in_op_a, t, round_operands);
    wb      = pre_round(in_op_b, t, round_operands);
    fa      = wa[22:0] & ~lowmask;
    fb      = wb[22:0] & ~lowmask;
    nan_a   = (wa[30:23] == TFM_EXP_ONES) && (fa != 23'd0);
    nan_b   = (wb[30:23] == TFM_EXP_ONES) && (fb != 23'd0);
    inf_a   = (wa[30:23] == TFM_EXP_ONES) && (fa == 23'd0);
    inf_b   = (wb[30:23] == TFM_EXP_ONES) && (fb == 23'd0);
    zero_a  = (wa[30:23] == 8'd0) && (fa == 23'd0);
    zero_b  = (wb[30:23] == 8'd0) && (fb == 23'd0);
    zs      = wa[31] ^ wb[31];
    ra      = {(wa[30:23] != 8'd0), fa};
    rb      = {(wb[30:23] != 8'd0), fb};
    la      = lzc24(ra);
    lb      = lzc24(rb);

    op_nxt.sign     = zs;
    op_nxt.special  = 1'b1;
    op_nxt.spec_val = 32'd0;
    priority if (nan_a || nan_b) begin
      op_nxt.spec_val = TFM_QNAN;
    end else if (inf_a) begin
      op_nxt.spec_val = {wa[31], TFM_EXP_ONES, 23'd0};
    end else if (zero_b) begin
      op_nxt.spec_val = {zs, 31'd0};
    end else if (inf_b) begin
      op_nxt.spec_val = {zs, TFM_EXP_ONES, 23'd0};
    end else if (zero_a) begin
      op_nxt.spec_val = {zs, 31'd0};
    end else begin
      op_nxt.special = 1'b0;
    end
    // denormals sit at exponent -126 before the shift
    op_nxt.ea = ((wa[30:23] == 8'd0) ? -10'sd126 : ($signed({2'b00, wa[30:23]}) - 10'sd127))
                - $signed({5'd0, la});
    op_nxt.eb = ((wb[30:23] == 8'd0) ? -10'sd126 : ($signed({2'b00, wb[30:23]}) - 10'sd127))
                - $signed({5'd0, lb});
    op_nxt.ma = ra << la;
    op_nxt.mb = rb << lb;
  end

  assign load    = push && !full;
  assign full    = valid_r && !f_take;
  assign f_valid = valid_r;
  assign f_op    = op_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (f_take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      op_r <= op_nxt;
    end
  end

endmodule

### design/tfm_fifo.sv
// ----------------------------------------------------------------------------
// tfm_fifo
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
module tfm_fifo #(
  parameter int DEPTH = tfm_pkg::TFM_QDEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  tfm_pkg::tfm_op_t wr_data,
  output logic             q_full,
  input  logic             rd_en,
  output tfm_pkg::tfm_op_t rd_data,
  output logic             q_empty
);
  import tfm_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tfm_op_t         mem_r [DEPTH];
  logic [AW-1:0]   wp_r, rp_r;
  logic [CW-1:0]   cnt_r;

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    bump = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign q_full  = (cnt_r == CW'(DEPTH));
  assign q_empty = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= bump(wp_r);
      if (rd_en) rp_r <= bump(rp_r);
      if (wr_en && !rd_en) cnt_r <= cnt_r + CW'(1);
      else if (rd_en && !wr_en) cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

### design/tfm_back.sv
// ----------------------------------------------------------------------------
// tfm_back
// Significand multiply, normalise, denormal shift, round to nearest even and
// result register, one item at a time.
// ----------------------------------------------------------------------------
module tfm_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [4:0]       trunc_bits,
  input  logic             q_empty,
  input  tfm_pkg::tfm_op_t q_data,
  output logic             q_pop,
  output logic             empty,
  input  logic             pop,
  output logic [31:0]      out_product
);
  import tfm_pkg::*;
`include "truncated_float32_multiplier_assert.svh"

  typedef enum logic [1:0] {B_IDLE, B_MUL, B_RND, B_DONE} bstate_t;

  bstate_t            state_r;
  tfm_op_t            op_r;
  logic [47:0]        p_r;
  logic signed [9:0]  ze_r;
  logic [31:0]        res_r, res_nxt;

  logic [4:0]         t;
  logic [47:0]        p1, p2;
  logic signed [9:0]  z1, z2, z3, d;
  logic [5:0]         sh;
  logic               lost, g, rs, l, up;
  logic [23:0]        q, qf;
  logic [24:0]        sum;
  logic [7:0]         ex;

  always_comb begin
    t = eff_trunc(trunc_bits);
    // bring the hidden bit to the top
    if (!p_r[47]) begin
      p1 = p_r << 1;
      z1 = ze_r - 10'sd1;
    end else begin
      p1 = p_r;
      z1 = ze_r;
    end
    // denormal range: shift right, keep lost bits as sticky
    if (z1 < -10'sd126) begin
      d  = -10'sd126 - z1;
      sh = (d > 10'sd47) ? 6'd48 : d[5:0];
      z2 = -10'sd126;
    end else begin
      d  = 10'sd0;
      sh = 6'd0;
      z2 = z1;
    end
    p2   = p1 >> sh;
    lost = ((p2 << sh) != p1);
    g    = p2[6'(t) + 6'd23];
    l    = p2[6'(t) + 6'd24];
    rs   = ((p2 & ((48'd1 << (6'(t) + 6'd23)) - 48'd1)) != 48'd0) || lost;
    q    = p2[47:24] & ~((24'd1 << t) - 24'd1);
    sum  = {1'b0, q} + (25'd1 << t);
    up   = g && (rs || l);
    qf   = up ? sum[23:0] : q;
    z3   = (up && sum[24]) ? z2 + 10'sd1 : z2;
    ex   = ((z3 == -10'sd126) && !qf[23]) ? 8'd0 : 8'(z3 + 10'sd127);
    if (op_r.special) begin
      res_nxt = op_r.spec_val;
    end else if (z3 > 10'sd127) begin
      res_nxt = {op_r.sign, TFM_EXP_ONES, 23'd0};
    end else begin
      res_nxt = {op_r.sign, ex, qf[22:0]};
    end
  end

  assign q_pop       = (state_r == B_IDLE) && !q_empty;
  assign empty       = (state_r != B_DONE);
  assign out_product = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      unique case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            op_r    <= q_data;
            state_r <= B_MUL;
          end
        end
        B_MUL: begin
          p_r     <= op_r.ma * op_r.mb;
          ze_r    <= op_r.ea + op_r.eb + 10'sd1;
          state_r <= B_RND;
        end
        B_RND: begin
          res_r   <= res_nxt;
          state_r <= B_DONE;
        end
        B_DONE: begin
          if (pop) state_r <= B_IDLE;
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  `TFM_ASSERT_NOW(a_pop_idle, q_pop, state_r == B_IDLE, "queue drained outside idle")
  `TFM_ASSERT_NEXT(a_take_mul, q_pop, state_r == B_MUL, "taken item did not advance to multiply")
  `TFM_ASSERT_NEXT(a_done_hold, (state_r == B_DONE) && !pop, !empty && $stable(out_product),
                   "result dropped before it was taken")

endmodule
